[hdl/tq_pkg.sv]
// Shared types and constants for the team queue core.
// Holds the request and status codes and the fixed field widths.
// No dependencies.
`default_nettype none

package tq_pkg;

    // Fixed widths of the transaction fields.
    localparam int TEAM_BITS   = 4;
    localparam int ACT_W       = 5;
    localparam int MSHIP_W     = TEAM_BITS + 1;

    // Register value after reset.
    localparam logic [ACT_W-1:0] ACTIVE_TEAMS_RESET = 5'd16;

    typedef enum logic [1:0] {
        REQ_ASSIGN  = 2'd0,
        REQ_ENQUEUE = 2'd1,
        REQ_DEQUEUE = 2'd2,
        REQ_CLEAR   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_NO_TEAM = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

endpackage

`default_nettype wire

[hdl/tq_ram.sv]
// Simple dual-port synchronous RAM for the team queue core.
// One write port and one read port with registered read data.
// No dependencies.
`default_nettype none

module tq_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 4
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[hdl/team_queue_core.sv]
// Team queue core: top level with the request sequencer and all queue state.
// Depends on tq_pkg and tq_ram.
//
// The core keeps members in per-team FIFOs and serves teams in the order in
// which they started waiting. After reset it runs a clearing pass over every
// entry of the membership table, during which s_ready stays low; cfg_we
// writes are taken at any time. It then works on one transaction at a time,
// stepping through reads of RAMs with registered read data (membership
// table, team pointers, team FIFO storage, team order) and writing back. An
// enqueue looks up the membership, then, for a usable team, reads the team
// pointers; a dequeue reads the team order, the team pointers, then the FIFO
// data. The result register lets the next request be accepted while a
// result waits for m_ready. Only a clear item empties the queues;
// memberships persist.
`default_nettype none

module team_queue_core
    import tq_pkg::*;
#(
    parameter int NUM_TEAMS      = 16,
    parameter int FIFO_DEPTH     = 16,
    parameter int MEMBER_ID_BITS = 10
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [ACT_W-1:0]          cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_req_type,
    input  logic [MEMBER_ID_BITS-1:0] s_member_id,
    input  logic [TEAM_BITS-1:0]      s_team_number,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_status,
    output logic                      m_value_valid,
    output logic [MEMBER_ID_BITS-1:0] m_member_out,
    output logic [TEAM_BITS-1:0]      m_team_out
);

    localparam int MW  = MEMBER_ID_BITS;
    localparam int TW  = $clog2(NUM_TEAMS);
    localparam int SW  = $clog2(FIFO_DEPTH);
    localparam int CW  = $clog2(FIFO_DEPTH + 1);
    localparam int OCW = $clog2(NUM_TEAMS + 1);
    localparam int TXW = TW + TEAM_BITS;
    localparam int FAW = TW + SW;
    localparam int TMW = SW + CW;

    typedef enum logic [7:0] {
        S_INIT     = 8'b0000_0001,
        S_IDLE     = 8'b0000_0010,
        S_ENQ_LOOK = 8'b0000_0100,
        S_ENQ_TEAM = 8'b0000_1000,
        S_DEQ_ORD  = 8'b0001_0000,
        S_DEQ_TEAM = 8'b0010_0000,
        S_DEQ_DATA = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } state_t;

    // Maps a team number onto a team table index.
    function automatic logic [TW-1:0] to_idx(input logic [TEAM_BITS-1:0] t);
        logic [TXW-1:0] w;
        w = TXW'(t);
        return w[TW-1:0];
    endfunction

    state_t state_reg, state_next;
    logic [MW-1:0]        init_cnt_reg, init_cnt_next;
    logic [MW-1:0]        member_reg, member_next;
    logic [TW-1:0]        cur_team_reg, cur_team_next;
    logic [ACT_W-1:0]     act_teams_reg;
    logic [TW-1:0]        order_head_reg, order_head_next;
    logic [OCW-1:0]       order_cnt_reg, order_cnt_next;
    logic [NUM_TEAMS-1:0] team_vld_reg, team_vld_next;

    status_t              res_status_reg, res_status_next;
    logic                 res_vld_reg, res_vld_next;
    logic [MW-1:0]        res_member_reg, res_member_next;
    logic [TEAM_BITS-1:0] res_team_reg, res_team_next;

    logic                 m_valid_reg, m_valid_next;
    status_t              m_status_reg, m_status_next;
    logic                 m_vv_reg, m_vv_next;
    logic [MW-1:0]        m_member_reg, m_member_next;
    logic [TEAM_BITS-1:0] m_team_reg, m_team_next;

    // RAM ports.
    logic               ms_we, ms_re;
    logic [MW-1:0]      ms_waddr, ms_raddr;
    logic [MSHIP_W-1:0] ms_wdata, ms_rdata;
    logic               tm_we, tm_re;
    logic [TW-1:0]      tm_waddr, tm_raddr;
    logic [TMW-1:0]     tm_wdata, tm_rdata;
    logic               ff_we, ff_re;
    logic [FAW-1:0]     ff_waddr, ff_raddr;
    logic [MW-1:0]      ff_wdata, ff_rdata;
    logic               od_we, od_re;
    logic [TW-1:0]      od_waddr, od_raddr;
    logic [TW-1:0]      od_wdata, od_rdata;

    logic                 acc;
    req_t                 req;
    logic                 ms_has;
    logic [TEAM_BITS-1:0] ms_team;
    logic                 lk_ok;
    logic [TW-1:0]        lk_idx;
    logic [TMW-1:0]       tm_eff;
    logic [SW-1:0]        cur_head;
    logic [CW-1:0]        cur_cnt;
    logic [SW:0]          slot_sum, slot_wrap;
    logic [SW-1:0]        slot;
    logic                 full;
    logic [SW:0]          head_inc;
    logic [SW-1:0]        next_head;
    logic [CW-1:0]        cnt_dec;
    logic [TW:0]          tail_sum, tail_wrap;
    logic [TW:0]          ohead_inc;
    logic [TW-1:0]        ohead_next;

    assign acc = s_valid && s_ready;
    assign req = req_t'(s_req_type);

    // Membership lookup result.
    assign ms_has  = ms_rdata[TEAM_BITS];
    assign ms_team = ms_rdata[TEAM_BITS-1:0];
    assign lk_idx  = to_idx(ms_team);
    assign lk_ok   = ms_has && (ACT_W'(ms_team) < act_teams_reg)
                     && (32'(ms_team) < NUM_TEAMS);

    // Team pointers; a team not written since the last clear reads as empty.
    assign tm_eff   = team_vld_reg[cur_team_reg] ? tm_rdata : '0;
    assign cur_head = tm_eff[CW +: SW];
    assign cur_cnt  = tm_eff[CW-1:0];
    assign full     = (cur_cnt >= CW'(FIFO_DEPTH));

    // Tail slot of the team FIFO.
    assign slot_sum  = {1'b0, cur_head} + (SW+1)'(cur_cnt);
    assign slot_wrap = (slot_sum >= (SW+1)'(FIFO_DEPTH))
                       ? slot_sum - (SW+1)'(FIFO_DEPTH) : slot_sum;
    assign slot      = slot_wrap[SW-1:0];

    // Head advance after a dequeue.
    assign head_inc  = {1'b0, cur_head} + (SW+1)'(1);
    assign next_head = (head_inc == (SW+1)'(FIFO_DEPTH)) ? '0 : head_inc[SW-1:0];
    assign cnt_dec   = cur_cnt - CW'(1);

    // Team order queue tail and head advance.
    assign tail_sum   = {1'b0, order_head_reg} + (TW+1)'(order_cnt_reg);
    assign tail_wrap  = (tail_sum >= (TW+1)'(NUM_TEAMS))
                        ? tail_sum - (TW+1)'(NUM_TEAMS) : tail_sum;
    assign ohead_inc  = {1'b0, order_head_reg} + (TW+1)'(1);
    assign ohead_next = (ohead_inc == (TW+1)'(NUM_TEAMS)) ? '0 : ohead_inc[TW-1:0];

    assign s_ready = (state_reg == S_IDLE);

    // Request sequencer.
    always_comb begin
        state_next      = state_reg;
        init_cnt_next   = init_cnt_reg;
        member_next     = member_reg;
        cur_team_next   = cur_team_reg;
        order_head_next = order_head_reg;
        order_cnt_next  = order_cnt_reg;
        team_vld_next   = team_vld_reg;
        res_status_next = res_status_reg;
        res_vld_next    = res_vld_reg;
        res_member_next = res_member_reg;
        res_team_next   = res_team_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_vv_next       = m_vv_reg;
        m_member_next   = m_member_reg;
        m_team_next     = m_team_reg;

        ms_we    = 1'b0;
        ms_waddr = init_cnt_reg;
        ms_wdata = '0;
        ms_re    = 1'b0;
        ms_raddr = s_member_id;
        tm_we    = 1'b0;
        tm_waddr = cur_team_reg;
        tm_wdata = '0;
        tm_re    = 1'b0;
        tm_raddr = lk_idx;
        ff_we    = 1'b0;
        ff_waddr = {cur_team_reg, slot};
        ff_wdata = member_reg;
        ff_re    = 1'b0;
        ff_raddr = {cur_team_reg, cur_head};
        od_we    = 1'b0;
        od_waddr = tail_wrap[TW-1:0];
        od_wdata = cur_team_reg;
        od_re    = 1'b0;
        od_raddr = order_head_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_INIT: begin
                ms_we         = 1'b1;
                init_cnt_next = init_cnt_reg + MW'(1);
                if (init_cnt_reg == '1) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (acc) begin
                    member_next     = s_member_id;
                    res_status_next = ST_OK;
                    res_vld_next    = 1'b0;
                    res_member_next = '0;
                    res_team_next   = '0;
                    unique case (req)
                        REQ_ASSIGN: begin
                            ms_we         = 1'b1;
                            ms_waddr      = s_member_id;
                            ms_wdata      = {1'b1, s_team_number};
                            res_team_next = s_team_number;
                            state_next    = S_DONE;
                        end
                        REQ_ENQUEUE: begin
                            ms_re      = 1'b1;
                            state_next = S_ENQ_LOOK;
                        end
                        REQ_DEQUEUE: begin
                            if (order_cnt_reg == '0) begin
                                res_status_next = ST_EMPTY;
                                state_next      = S_DONE;
                            end else begin
                                od_re      = 1'b1;
                                state_next = S_DEQ_ORD;
                            end
                        end
                        REQ_CLEAR: begin
                            team_vld_next   = '0;
                            order_head_next = '0;
                            order_cnt_next  = '0;
                            state_next      = S_DONE;
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_ENQ_LOOK: begin
                if (lk_ok) begin
                    cur_team_next = lk_idx;
                    tm_re         = 1'b1;
                    tm_raddr      = lk_idx;
                    state_next    = S_ENQ_TEAM;
                end else begin
                    res_status_next = ST_NO_TEAM;
                    state_next      = S_DONE;
                end
            end
            S_ENQ_TEAM: begin
                res_team_next = TEAM_BITS'(cur_team_reg);
                if (full) begin
                    res_status_next = ST_FULL;
                end else begin
                    ff_we                       = 1'b1;
                    tm_we                       = 1'b1;
                    tm_wdata                    = {cur_head, cur_cnt + CW'(1)};
                    team_vld_next[cur_team_reg] = 1'b1;
                    // A team that was not waiting joins the order queue.
                    if (cur_cnt == '0) begin
                        od_we          = 1'b1;
                        order_cnt_next = order_cnt_reg + OCW'(1);
                    end
                end
                state_next = S_DONE;
            end
            S_DEQ_ORD: begin
                cur_team_next = od_rdata;
                tm_re         = 1'b1;
                tm_raddr      = od_rdata;
                state_next    = S_DEQ_TEAM;
            end
            S_DEQ_TEAM: begin
                ff_re = 1'b1;
                tm_we = 1'b1;
                // A drained team leaves the order queue with its head reset.
                if (cnt_dec == '0) begin
                    tm_wdata        = '0;
                    order_head_next = ohead_next;
                    order_cnt_next  = order_cnt_reg - OCW'(1);
                end else begin
                    tm_wdata = {next_head, cnt_dec};
                end
                state_next = S_DEQ_DATA;
            end
            S_DEQ_DATA: begin
                res_vld_next    = 1'b1;
                res_member_next = ff_rdata;
                res_team_next   = TEAM_BITS'(cur_team_reg);
                state_next      = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_vv_next     = res_vld_reg;
                    m_member_next = res_member_reg;
                    m_team_next   = res_team_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_INIT;
            init_cnt_reg   <= '0;
            act_teams_reg  <= ACTIVE_TEAMS_RESET;
            order_head_reg <= '0;
            order_cnt_reg  <= '0;
            team_vld_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            init_cnt_reg   <= init_cnt_next;
            order_head_reg <= order_head_next;
            order_cnt_reg  <= order_cnt_next;
            team_vld_reg   <= team_vld_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_we) begin
                act_teams_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        member_reg     <= member_next;
        cur_team_reg   <= cur_team_next;
        res_status_reg <= res_status_next;
        res_vld_reg    <= res_vld_next;
        res_member_reg <= res_member_next;
        res_team_reg   <= res_team_next;
        m_status_reg   <= m_status_next;
        m_vv_reg       <= m_vv_next;
        m_member_reg   <= m_member_next;
        m_team_reg     <= m_team_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_value_valid = m_vv_reg;
    assign m_member_out  = m_member_reg;
    assign m_team_out    = m_team_reg;

    // Membership table: has-team flag and team number per member.
    tq_ram #(.DATA_W(MSHIP_W), .ADDR_W(MW)) u_mship_ram (
        .aclk    (aclk),
        .wr_en   (ms_we),
        .wr_addr (ms_waddr),
        .wr_data (ms_wdata),
        .rd_en   (ms_re),
        .rd_addr (ms_raddr),
        .rd_data (ms_rdata)
    );

    // Team pointers: FIFO head and fill count per team.
    tq_ram #(.DATA_W(TMW), .ADDR_W(TW)) u_team_ram (
        .aclk    (aclk),
        .wr_en   (tm_we),
        .wr_addr (tm_waddr),
        .wr_data (tm_wdata),
        .rd_en   (tm_re),
        .rd_addr (tm_raddr),
        .rd_data (tm_rdata)
    );

    // Team FIFO storage, one power-of-two region per team.
    tq_ram #(.DATA_W(MW), .ADDR_W(FAW)) u_fifo_ram (
        .aclk    (aclk),
        .wr_en   (ff_we),
        .wr_addr (ff_waddr),
        .wr_data (ff_wdata),
        .rd_en   (ff_re),
        .rd_addr (ff_raddr),
        .rd_data (ff_rdata)
    );

    // Team order queue storage.
    tq_ram #(.DATA_W(TW), .ADDR_W(TW)) u_order_ram (
        .aclk    (aclk),
        .wr_en   (od_we),
        .wr_addr (od_waddr),
        .wr_data (od_wdata),
        .rd_en   (od_re),
        .rd_addr (od_raddr),
        .rd_data (od_rdata)
    );

`ifndef SYNTH
    // The order queue never holds more teams than exist.
    a_order_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        order_cnt_reg <= OCW'(NUM_TEAMS))
        else $error("order queue count exceeds team count");

    // Outside a clear, the order queue grows or shrinks by one team at most.
    a_order_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && !$past(acc && (req == REQ_CLEAR))) |->
        ((order_cnt_reg == $past(order_cnt_reg)) ||
         (order_cnt_reg == $past(order_cnt_reg) + OCW'(1)) ||
         (order_cnt_reg == $past(order_cnt_reg) - OCW'(1))))
        else $error("order queue count jumped");

    // A new result appears only when the sequencer hands one over.
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the hand-over state");
`endif

endmodule

`default_nettype wire

[test/team_queue_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for team_queue_core: directed and random requests,
// checked against a behavioral team queue model kept in a scoreboard class.
// Depends on tq_pkg and the team_queue_core RTL only.

module team_queue_core_tb;
    import tq_pkg::*;

    localparam int TEAMS       = 16;
    localparam int LANE_DEPTH  = 16;
    localparam int MID_W       = 10;
    localparam int MEMBERS     = 1 << MID_W;
    localparam int ROSTER_SIZE = 48;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_WAIT  = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASES      = 6;

    typedef struct packed {
        logic [1:0]       status;
        logic             value_valid;
        logic [MID_W-1:0] member;
        logic [3:0]       team;
    } tq_result_t;

    // Behavioral team queue plus the list of results still owed by the core.
    class tq_scoreboard;
        bit               has_team     [MEMBERS];
        logic [3:0]       team_of      [MEMBERS];
        logic [MID_W-1:0] lane_mem     [TEAMS][LANE_DEPTH];
        int               lane_head    [TEAMS];
        int               lane_count   [TEAMS];
        bit               lane_waiting [TEAMS];
        logic [3:0]       order_ring   [TEAMS];
        int               order_head;
        int               order_count;
        int               active_teams;
        int               failures;
        tq_result_t       results_owed [$];

        function new();
            foreach (has_team[i]) begin
                has_team[i] = 1'b0;
                team_of[i]  = '0;
            end
            foreach (lane_mem[t, s]) lane_mem[t][s] = '0;
            foreach (order_ring[i]) order_ring[i] = '0;
            empty_all();
            active_teams = ACTIVE_TEAMS_RESET;
            failures     = 0;
        endfunction

        // A clear empties every queue but keeps the memberships.
        function void empty_all();
            foreach (lane_head[t]) begin
                lane_head[t]    = 0;
                lane_count[t]   = 0;
                lane_waiting[t] = 1'b0;
            end
            order_head  = 0;
            order_count = 0;
        endfunction

        function void set_active(logic [ACT_W-1:0] value);
            active_teams = value;
        endfunction

        function int pending();
            return results_owed.size();
        endfunction

        // Applies one accepted transaction and queues the result it must give.
        function void note_request(req_t rq, logic [MID_W-1:0] id, logic [3:0] tn);
            tq_result_t r;
            int         t;
            int         h;
            r = '0;
            case (rq)
                REQ_ASSIGN: begin
                    has_team[id] = 1'b1;
                    team_of[id]  = tn;
                    r.team       = tn;
                end
                REQ_ENQUEUE: begin
                    t = team_of[id];
                    if (!has_team[id] || t >= active_teams) begin
                        r.status = ST_NO_TEAM;
                    end else if (lane_count[t] >= LANE_DEPTH) begin
                        r.status = ST_FULL;
                        r.team   = 4'(t);
                    end else begin
                        lane_mem[t][(lane_head[t] + lane_count[t]) % LANE_DEPTH] = id;
                        lane_count[t]++;
                        // A team joins the order queue only on its first waiting member.
                        if (!lane_waiting[t]) begin
                            lane_waiting[t] = 1'b1;
                            order_ring[(order_head + order_count) % TEAMS] = 4'(t);
                            order_count++;
                        end
                        r.team = 4'(t);
                    end
                end
                REQ_DEQUEUE: begin
                    if (order_count == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        t             = order_ring[order_head];
                        h             = lane_head[t];
                        r.value_valid = 1'b1;
                        r.member      = lane_mem[t][h];
                        r.team        = 4'(t);
                        lane_head[t]  = (h + 1) % LANE_DEPTH;
                        lane_count[t]--;
                        // A drained team leaves the order queue.
                        if (lane_count[t] == 0) begin
                            lane_waiting[t] = 1'b0;
                            lane_head[t]    = 0;
                            order_head      = (order_head + 1) % TEAMS;
                            order_count--;
                        end
                    end
                end
                default: begin
                    empty_all();
                end
            endcase
            results_owed.push_back(r);
        endfunction

        function void flag(string what, tq_result_t want, tq_result_t got);
            failures++;
            if (failures <= 10) begin
                $display("ERROR %0t: %s: expected status=%0d valid=%0d member=%0d team=%0d,",
                         $time, what, want.status, want.value_valid, want.member, want.team);
                $display("      got status=%0d valid=%0d member=%0d team=%0d",
                         got.status, got.value_valid, got.member, got.team);
            end
        endfunction

        // Compares one accepted result with the oldest one owed.
        function void check_result(logic [1:0] st, logic vv, logic [MID_W-1:0] mo,
                                   logic [3:0] to);
            tq_result_t want;
            tq_result_t got;
            got = '{status: st, value_valid: vv, member: mo, team: to};
            if (results_owed.size() == 0) begin
                flag("result with no transaction pending", '0, got);
            end else begin
                want = results_owed.pop_front();
                if (got.status !== want.status || got.value_valid !== want.value_valid ||
                    got.member !== want.member || got.team !== want.team) begin
                    flag("result mismatch", want, got);
                end
            end
        endfunction
    endclass

    logic             aclk          = 1'b0;
    logic             aresetn       = 1'b0;
    logic             cfg_we        = 1'b0;
    logic [ACT_W-1:0] cfg_wdata     = '0;
    logic             s_valid       = 1'b0;
    logic             s_ready;
    req_t             s_req_type    = REQ_ASSIGN;
    logic [MID_W-1:0] s_member_id   = '0;
    logic [3:0]       s_team_number = '0;
    logic             m_valid;
    logic             m_ready       = 1'b0;
    logic [1:0]       m_status;
    logic             m_value_valid;
    logic [MID_W-1:0] m_member_out;
    logic [3:0]       m_team_out;

    tq_scoreboard     sb;
    int               sender_idle_pct = 0;
    int               receiver_idle_pct = 0;
    int               hold_request = 0;
    logic [MID_W-1:0] roster [ROSTER_SIZE];

    // Per-phase register value (negative means pick one at random),
    // share of enqueues and number of random transactions.
    int phase_cfg   [PHASES] = '{31, 1, 0, 5, -1, 16};
    int phase_enq   [PHASES] = '{45, 70, 40, 50, 48, 45};
    int phase_items [PHASES] = '{300, 300, 200, 350, 350, 300};

    team_queue_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_member_id   (s_member_id),
        .s_team_number (s_team_number),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_value_valid (m_value_valid),
        .m_member_out  (m_member_out),
        .m_team_out    (m_team_out)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Offers one transaction, after a random gap, and waits until it is taken.
    task automatic issue(input req_t rq, input logic [MID_W-1:0] id, input logic [3:0] tn);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < sender_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_req_type    <= rq;
        s_member_id   <= id;
        s_team_number <= tn;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(rq, id, tn);
    endtask

    // Lets every owed result come out before the register is touched.
    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_active(input logic [ACT_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.set_active(value);
    endtask

    // One random transaction; most members come from a fixed roster so that
    // enqueues find a team and the team FIFOs fill up.
    task automatic random_item(input int enq_pct);
        int               roll;
        int               lim;
        logic [MID_W-1:0] id;
        logic [3:0]       tn;
        roll = $urandom_range(99);
        if ($urandom_range(99) < 85) id = roster[$urandom_range(ROSTER_SIZE - 1)];
        else id = MID_W'($urandom);
        tn  = 4'($urandom);
        lim = (sb.active_teams == 0 || sb.active_teams > TEAMS) ? TEAMS : sb.active_teams;
        if (roll < 2) begin
            issue(REQ_CLEAR, id, tn);
        end else if (roll < 14) begin
            if ($urandom_range(99) < 70) tn = 4'($urandom_range(lim - 1));
            issue(REQ_ASSIGN, id, tn);
        end else if (roll < 14 + enq_pct) begin
            issue(REQ_ENQUEUE, id, tn);
        end else begin
            issue(REQ_DEQUEUE, id, tn);
        end
    endtask

    // Result side: checks each accepted result and stalls at random, or for
    // one long stretch when a hold-off is requested.
    initial begin : result_side
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                sb.check_result(m_status, m_value_valid, m_member_out, m_team_out);
            end
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= receiver_idle_pct);
            end
        end
    end

    // Ends the run when no transaction moves for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        int cfg_value;
        sb = new();
        foreach (roster[i]) roster[i] = MID_W'($urandom);
        roster[0] = '0;
        roster[1] = '1;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        write_active(ACTIVE_TEAMS_RESET);
        sender_idle_pct   = 16;
        receiver_idle_pct = 64;

        // Empty dequeue and an enqueue from a member with no team.
        issue(REQ_DEQUEUE, 10'd0, 4'd0);
        issue(REQ_ENQUEUE, 10'd1023, 4'd15);
        // Memberships at the extremes of member id and team.
        issue(REQ_ASSIGN, 10'd0, 4'd0);
        issue(REQ_ASSIGN, 10'd1023, 4'd15);
        issue(REQ_ASSIGN, 10'h155, 4'd3);
        issue(REQ_ASSIGN, 10'h2AA, 4'd3);
        issue(REQ_ASSIGN, 10'd7, 4'd0);
        // Three teams start waiting; later arrivals join their team.
        issue(REQ_ENQUEUE, 10'd1023, 4'd0);
        issue(REQ_ENQUEUE, 10'h155, 4'd15);
        issue(REQ_ENQUEUE, 10'd0, 4'd0);
        issue(REQ_ENQUEUE, 10'h2AA, 4'd0);
        issue(REQ_ENQUEUE, 10'd7, 4'd0);
        // A queued member keeps the team it was enqueued with.
        issue(REQ_ASSIGN, 10'h155, 4'd9);
        repeat (5) issue(REQ_DEQUEUE, 10'h3FF, 4'hF);
        issue(REQ_DEQUEUE, 10'd0, 4'd0);
        // A clear empties the queues but the membership survives it.
        issue(REQ_ENQUEUE, 10'h155, 4'd0);
        issue(REQ_CLEAR, 10'd0, 4'd0);
        issue(REQ_DEQUEUE, 10'd0, 4'd0);
        issue(REQ_ENQUEUE, 10'h155, 4'd0);
        issue(REQ_DEQUEUE, 10'd0, 4'd0);
        s_valid <= 1'b0;

        // Random phases under different register values and idle patterns.
        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            cfg_value = (phase_cfg[p] < 0) ? $urandom_range(2, 15) : phase_cfg[p];
            write_active(ACT_W'(cfg_value));
            if (p < 2) begin
                sender_idle_pct   = 16;
                receiver_idle_pct = 64;
            end else if (p < 4) begin
                sender_idle_pct   = 64;
                receiver_idle_pct = 16;
            end else begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            // Back-pressure: the result side stops long enough to stall the input.
            if (p == 1) hold_request = HOLD_CYCLES;
            repeat (phase_items[p]) random_item(phase_enq[p]);
            s_valid <= 1'b0;
        end

        wait_drained();
        if (sb.failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[team_queue_core.f]
hdl/tq_pkg.sv
hdl/tq_ram.sv
hdl/team_queue_core.sv
test/team_queue_core_tb.sv
